>>> rtl/vqdm_pkg.sv
// Shared types and constants for the virtqueue descriptor manager.
`default_nettype none

package vqdm_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_PICK,
    ST_LINK,
    ST_CHECK,
    ST_FETCH,
    ST_WALK,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    MOD_AVAIL,
    MOD_SLOT,
    MOD_HEAD
  } mod_phase_t;

  localparam logic OP_SUBMIT  = 1'b0;
  localparam logic OP_CONSUME = 1'b1;

  localparam logic [3:0] QLOG2_RESET = 4'd8;
  localparam int         GRP         = 16;
  localparam int         IDX_OUT_W   = 8;
  localparam int         FREED_W     = 9;

  typedef struct packed {
    logic [7:0]  desc_index;
    logic        no_free;
    logic        notify;
    logic [15:0] avail_count;
    logic        nothing_ready;
    logic [15:0] done_tag;
    logic [31:0] done_len;
    logic [8:0]  freed_count;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/virtqueue_descriptor_manager_unit.sv
// Driver side of one split virtqueue: descriptor allocation, publishing and completion.
`default_nettype none

// Each request yields exactly one result, and a new request is taken once the previous result
// has been loaded into the output register. A submit passes through a free-map group scan, a
// group pick with descriptor write and a result load, with a link step after the pick when it
// extends an open chain, since the previous tail's link is rewritten through the single write
// port of the link memory. A consume with no new used entry goes from its check to the result
// load. A completing consume checks, fetches, walks the freed chain one descriptor per cycle
// through registered link memory reads, and loads the result. When QUEUE_LEN is not a power
// of two and the programmed queue size exceeds it, ring positions and the used head are
// reduced modulo QUEUE_LEN by a reciprocal multiplication with a registered quotient. A submit
// that ends its chain reduces its ring position first, a completing consume its ring slot and
// used head. A stalled result in the output register holds the next result in its load step.
module virtqueue_descriptor_manager_unit #(
  parameter int QUEUE_LEN = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [63:0] buf_addr,
  input  wire logic [31:0] buf_len,
  input  wire logic        device_writes,
  input  wire logic        chain_end,
  input  wire logic [15:0] request_tag,
  input  wire logic [15:0] used_idx,
  input  wire logic [7:0]  used_head,
  input  wire logic [31:0] used_len,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       desc_index,
  output logic             no_free,
  output logic             notify,
  output logic [15:0]      avail_count,
  output logic             nothing_ready,
  output logic [15:0]      done_tag,
  output logic [31:0]      done_len,
  output logic [8:0]       freed_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data
);

  localparam int IW    = (QUEUE_LEN > 1) ? $clog2(QUEUE_LEN) : 1;
  localparam int NG    = (QUEUE_LEN + vqdm_pkg::GRP - 1) / vqdm_pkg::GRP;
  localparam int STW   = $clog2(QUEUE_LEN + 1);
  localparam bit QPOW2 = ((QUEUE_LEN & (QUEUE_LEN - 1)) == 0);
  // Reciprocal of QUEUE_LEN, exact for every 16-bit dividend.
  localparam int RSH   = 16 + $clog2(QUEUE_LEN);
  localparam logic [17:0] RMUL =
    18'(((64'd1 << RSH) + 64'(QUEUE_LEN) - 64'd1) / 64'(QUEUE_LEN));

  typedef struct packed {
    logic          more;
    logic [IW-1:0] ptr;
  } link_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [31:0] len;
    logic        wr;
  } desc_t;

  vqdm_pkg::state_t     state, state_next;
  vqdm_pkg::mod_phase_t mod_phase;
  vqdm_pkg::result_t    res;

  logic [3:0]  qlog2;
  logic [QUEUE_LEN-1:0] free_map;

  // Descriptor body, descriptor links, available ring slots and slot tags.
  desc_t         desc_mem [QUEUE_LEN];
  link_t         link_mem [QUEUE_LEN];
  logic [IW-1:0] ring_mem [QUEUE_LEN];
  logic [15:0]   tag_mem  [QUEUE_LEN];

  link_t         link_q;
  logic [15:0]   tag_q;

  logic [15:0]   avail_index, last_used;
  logic [IW-1:0] chain_head, chain_tail;
  logic          chain_open;

  logic          wr_q, end_q;
  logic [63:0]   addr_q;
  logic [31:0]   len_q, ulen_q;
  logic [15:0]   rtag_q, uidx_q;
  logic [7:0]    uhead_q;

  logic [IW-1:0] slot_q, d_cur, d_new, tail_prev;
  logic [STW-1:0] steps;

  logic [15:0]   mod_x, mod_q, mod_q_c, mod_rem;
  logic          mod_step;
  logic [33:0]   mod_prod;
  logic [31:0]   mod_back;

  logic          grp_any  [NG];
  logic [3:0]    grp_first[NG];
  logic          grp_any_c  [NG];
  logic [3:0]    grp_first_c[NG];

  logic [16:0]   pow_n, n;
  logic          use_mask;
  logic [15:0]   mask16;

  logic          pick_found;
  logic [IW-1:0] pick_d;

  logic          link_rd_en;
  logic [IW-1:0] link_rd_addr;
  logic [IW-1:0] nxt;
  logic [STW-1:0] steps_inc;
  logic          walk_last;
  logic          out_load;

  // Fit a descriptor number to the 8-bit result field.
  function automatic logic [7:0] IDX_OUT_CAST(input logic [IW-1:0] d);
    logic [31:0] wide;
    wide = 32'(d);
    return wide[vqdm_pkg::IDX_OUT_W-1:0];
  endfunction

  function automatic logic [8:0] FREED_CAST(input logic [STW-1:0] s);
    logic [31:0] wide;
    wide = 32'(s);
    return wide[vqdm_pkg::FREED_W-1:0];
  endfunction

  // Queue size in use: a power of two, capped at QUEUE_LEN.
  always_comb begin
    pow_n    = 17'd1 << qlog2;
    use_mask = QPOW2 || (pow_n <= 17'(QUEUE_LEN));
    n        = (pow_n <= 17'(QUEUE_LEN)) ? pow_n : 17'(QUEUE_LEN);
    mask16   = 16'(n - 17'd1);
  end

  // Per-group lowest free descriptor below the queue size.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any_c[g]   = 1'b0;
      grp_first_c[g] = '0;
      for (int j = vqdm_pkg::GRP - 1; j >= 0; j--) begin
        if ((g * vqdm_pkg::GRP + j) < QUEUE_LEN) begin
          if (free_map[g * vqdm_pkg::GRP + j] && (17'(g * vqdm_pkg::GRP + j) < n)) begin
            grp_any_c[g]   = 1'b1;
            grp_first_c[g] = 4'(j);
          end
        end
      end
    end
  end

  always_comb begin
    pick_found = 1'b0;
    pick_d     = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        pick_found = 1'b1;
        pick_d     = IW'(g * vqdm_pkg::GRP + int'(grp_first[g]));
      end
    end
  end

  // Remainder by QUEUE_LEN: the quotient comes from the reciprocal in the first step and is
  // multiplied back and subtracted in the second.
  always_comb begin
    mod_prod = 34'(mod_x) * 34'(RMUL);
    mod_q_c  = 16'(mod_prod >> RSH);
    mod_back = 32'(mod_q) * 32'(QUEUE_LEN);
    mod_rem  = 16'(32'(mod_x) - mod_back);
  end

  always_comb begin
    nxt       = use_mask ? (link_q.ptr & IW'(mask16)) : link_q.ptr;
    steps_inc = steps + STW'(1);
    walk_last = !link_q.more || (32'(steps_inc) >= 32'(n));
    out_load  = !out_valid || !out_stall;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      vqdm_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (op == vqdm_pkg::OP_CONSUME) begin
            state_next = vqdm_pkg::ST_CHECK;
          end else if (chain_end && !use_mask) begin
            state_next = vqdm_pkg::ST_MOD;
          end else begin
            state_next = vqdm_pkg::ST_SCAN;
          end
        end
      end
      vqdm_pkg::ST_MOD: begin
        if (mod_step) begin
          case (mod_phase)
            vqdm_pkg::MOD_AVAIL: state_next = vqdm_pkg::ST_SCAN;
            vqdm_pkg::MOD_SLOT:  state_next = vqdm_pkg::ST_MOD;
            vqdm_pkg::MOD_HEAD:  state_next = vqdm_pkg::ST_FETCH;
            default:             state_next = vqdm_pkg::ST_IDLE;
          endcase
        end
      end
      vqdm_pkg::ST_SCAN: state_next = vqdm_pkg::ST_PICK;
      vqdm_pkg::ST_PICK: begin
        state_next = (pick_found && chain_open) ? vqdm_pkg::ST_LINK : vqdm_pkg::ST_RESULT;
      end
      vqdm_pkg::ST_LINK: state_next = vqdm_pkg::ST_RESULT;
      vqdm_pkg::ST_CHECK: begin
        if (uidx_q == last_used) begin
          state_next = vqdm_pkg::ST_RESULT;
        end else if (use_mask) begin
          state_next = vqdm_pkg::ST_FETCH;
        end else begin
          state_next = vqdm_pkg::ST_MOD;
        end
      end
      vqdm_pkg::ST_FETCH: state_next = vqdm_pkg::ST_WALK;
      vqdm_pkg::ST_WALK: begin
        if (walk_last) begin
          state_next = vqdm_pkg::ST_RESULT;
        end
      end
      vqdm_pkg::ST_RESULT: begin
        if (out_load) begin
          state_next = vqdm_pkg::ST_IDLE;
        end
      end
      default: state_next = vqdm_pkg::ST_IDLE;
    endcase
  end

  // Handshake and memory read control.
  always_comb begin
    in_stall     = (state != vqdm_pkg::ST_IDLE);
    cfg_ready    = 1'b1;
    link_rd_en   = 1'b0;
    link_rd_addr = d_cur;
    case (state)
      vqdm_pkg::ST_FETCH: link_rd_en = 1'b1;
      vqdm_pkg::ST_WALK: begin
        link_rd_en   = !walk_last;
        link_rd_addr = nxt;
      end
      default: link_rd_en = 1'b0;
    endcase
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (link_rd_en) begin
      link_q <= link_mem[link_rd_addr];
    end
    if (state == vqdm_pkg::ST_FETCH) begin
      tag_q <= tag_mem[slot_q];
    end
    if (state == vqdm_pkg::ST_PICK && pick_found) begin
      desc_mem[pick_d] <= '{addr: addr_q, len: len_q, wr: wr_q};
      link_mem[pick_d] <= '{more: 1'b0, ptr: '0};
      if (end_q) begin
        ring_mem[slot_q] <= chain_open ? chain_head : pick_d;
        tag_mem[slot_q]  <= rtag_q;
      end
    end else if (state == vqdm_pkg::ST_LINK) begin
      link_mem[tail_prev] <= '{more: 1'b1, ptr: d_new};
    end
  end

  // Request path.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= vqdm_pkg::ST_IDLE;
      qlog2       <= vqdm_pkg::QLOG2_RESET;
      free_map    <= '1;
      avail_index <= '0;
      last_used   <= '0;
      chain_head  <= '0;
      chain_tail  <= '0;
      chain_open  <= 1'b0;
      out_valid   <= 1'b0;
      mod_phase   <= vqdm_pkg::MOD_AVAIL;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        qlog2 <= cfg_data;
      end
      if (state == vqdm_pkg::ST_RESULT && out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        vqdm_pkg::ST_IDLE: begin
          if (in_valid) begin
            addr_q  <= buf_addr;
            len_q   <= buf_len;
            wr_q    <= device_writes;
            end_q   <= chain_end;
            rtag_q  <= request_tag;
            uidx_q  <= used_idx;
            uhead_q <= used_head;
            ulen_q  <= used_len;
            slot_q  <= IW'(avail_index & mask16);
            mod_x   <= avail_index;
            mod_step <= 1'b0;
            mod_phase <= vqdm_pkg::MOD_AVAIL;
          end
        end
        vqdm_pkg::ST_MOD: begin
          mod_step <= !mod_step;
          if (!mod_step) begin
            mod_q <= mod_q_c;
          end else begin
            case (mod_phase)
              vqdm_pkg::MOD_AVAIL: slot_q <= IW'(mod_rem);
              vqdm_pkg::MOD_SLOT: begin
                slot_q    <= IW'(mod_rem);
                mod_x     <= {8'd0, uhead_q};
                mod_phase <= vqdm_pkg::MOD_HEAD;
              end
              vqdm_pkg::MOD_HEAD:  d_cur <= IW'(mod_rem);
              default:             d_cur <= d_cur;
            endcase
          end
        end
        vqdm_pkg::ST_SCAN: begin
          grp_any   <= grp_any_c;
          grp_first <= grp_first_c;
        end
        vqdm_pkg::ST_PICK: begin
          res <= '{desc_index: pick_found ? IDX_OUT_CAST(pick_d) : 8'd0,
                   no_free: !pick_found,
                   notify: pick_found && end_q,
                   avail_count: (pick_found && end_q) ? avail_index + 16'd1 : avail_index,
                   nothing_ready: 1'b0, done_tag: 16'd0, done_len: 32'd0,
                   freed_count: 9'd0};
          if (pick_found) begin
            free_map[pick_d] <= 1'b0;
            d_new      <= pick_d;
            tail_prev  <= chain_tail;
            chain_tail <= pick_d;
            if (!chain_open) begin
              chain_head <= pick_d;
            end
            if (end_q) begin
              avail_index <= avail_index + 16'd1;
              chain_open  <= 1'b0;
            end else begin
              chain_open <= 1'b1;
            end
          end
        end
        vqdm_pkg::ST_CHECK: begin
          res <= '{desc_index: 8'd0, no_free: 1'b0, notify: 1'b0,
                   avail_count: avail_index,
                   nothing_ready: (uidx_q == last_used),
                   done_tag: 16'd0, done_len: 32'd0, freed_count: 9'd0};
          steps <= '0;
          if (uidx_q != last_used) begin
            slot_q    <= IW'(last_used & mask16);
            d_cur     <= IW'({8'd0, uhead_q} & mask16);
            mod_x     <= last_used;
            mod_step  <= 1'b0;
            mod_phase <= vqdm_pkg::MOD_SLOT;
          end
        end
        vqdm_pkg::ST_WALK: begin
          free_map[d_cur] <= 1'b1;
          steps <= steps_inc;
          d_cur <= nxt;
          if (walk_last) begin
            res <= '{desc_index: 8'd0, no_free: 1'b0, notify: 1'b0,
                     avail_count: res.avail_count, nothing_ready: 1'b0,
                     done_tag: tag_q, done_len: ulen_q,
                     freed_count: FREED_CAST(steps_inc)};
            last_used <= last_used + 16'd1;
          end
        end
        vqdm_pkg::ST_RESULT: begin
          if (out_load) begin
            desc_index    <= res.desc_index;
            no_free       <= res.no_free;
            notify        <= res.notify;
            avail_count   <= res.avail_count;
            nothing_ready <= res.nothing_ready;
            done_tag      <= res.done_tag;
            done_len      <= res.done_len;
            freed_count   <= res.freed_count;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the virtqueue descriptor manager with a predicting scoreboard.
`default_nettype none

class vq_scoreboard;
  bit [3:0]  qlog;
  bit [1:0]  flg[256];
  bit [7:0]  lnk[256];
  bit        fre[256];
  bit        dwr[256];
  bit [15:0] tag[256];
  bit        swr[256];
  bit [15:0] aidx;
  bit [15:0] lused;
  bit [7:0]  chead;
  bit [7:0]  ctail;
  bit        copen;
  bit        last_pub;
  vqdm_pkg::result_t want[$];
  int        errors;

  function new();
    qlog = vqdm_pkg::QLOG2_RESET;
    foreach (fre[i]) begin
      fre[i] = 1'b1;
      dwr[i] = 1'b0;
      swr[i] = 1'b0;
    end
    aidx = '0;
    lused = '0;
    chead = '0;
    ctail = '0;
    copen = 1'b0;
    errors = 0;
  endfunction

  function int qn();
    int n;
    n = 1 << qlog;
    if (n > 256) n = 256;
    return n;
  endfunction

  // A completion may only touch a slot tag and descriptors that have been written.
  function bit safe(bit [7:0] h);
    int n, d, steps;
    n = qn();
    if (!swr[lused % n]) return 0;
    d = h % n;
    steps = 0;
    forever begin
      if (!dwr[d]) return 0;
      steps++;
      if (!flg[d][0] || steps >= n) return 1;
      d = lnk[d] % n;
    end
  endfunction

  function void note_request(bit op, bit dw, bit ce, bit [15:0] rt, bit [15:0] ui,
                             bit [7:0] uh, bit [31:0] ul);
    vqdm_pkg::result_t r;
    int n, d, found, steps, slot;
    n = qn();
    r = '0;
    last_pub = 1'b0;
    if (op == vqdm_pkg::OP_SUBMIT) begin
      found = n;
      for (d = 0; d < n; d++) begin
        if (fre[d]) begin
          found = d;
          break;
        end
      end
      if (found >= n) begin
        r.no_free = 1'b1;
      end else begin
        fre[found] = 1'b0;
        dwr[found] = 1'b1;
        flg[found] = dw ? 2'b10 : 2'b00;
        lnk[found] = '0;
        if (copen) begin
          flg[ctail][0] = 1'b1;
          lnk[ctail] = 8'(found);
        end else begin
          chead = 8'(found);
          copen = 1'b1;
        end
        ctail = 8'(found);
        r.desc_index = 8'(found);
        if (ce) begin
          slot = aidx % n;
          tag[slot] = rt;
          swr[slot] = 1'b1;
          aidx++;
          copen = 1'b0;
          r.notify = 1'b1;
          last_pub = 1'b1;
        end
      end
    end else if (ui == lused) begin
      r.nothing_ready = 1'b1;
    end else begin
      r.done_tag = tag[lused % n];
      r.done_len = ul;
      d = uh % n;
      steps = 0;
      forever begin
        fre[d] = 1'b1;
        steps++;
        if (!flg[d][0] || steps >= n) break;
        d = lnk[d] % n;
      end
      r.freed_count = 9'(steps);
      lused++;
    end
    r.avail_count = aidx;
    want.push_back(r);
  endfunction

  function void check(vqdm_pkg::result_t got);
    vqdm_pkg::result_t e;
    if (want.size() == 0) begin
      $error("result with no request outstanding");
      errors++;
      return;
    end
    e = want.pop_front();
    if (got.desc_index !== e.desc_index) begin
      $error("desc_index expected %0d actual %0d", e.desc_index, got.desc_index);
      errors++;
    end
    if (got.no_free !== e.no_free) begin
      $error("no_free expected %0d actual %0d", e.no_free, got.no_free);
      errors++;
    end
    if (got.notify !== e.notify) begin
      $error("notify expected %0d actual %0d", e.notify, got.notify);
      errors++;
    end
    if (got.avail_count !== e.avail_count) begin
      $error("avail_count expected %0d actual %0d", e.avail_count, got.avail_count);
      errors++;
    end
    if (got.nothing_ready !== e.nothing_ready) begin
      $error("nothing_ready expected %0d actual %0d", e.nothing_ready, got.nothing_ready);
      errors++;
    end
    if (got.done_tag !== e.done_tag) begin
      $error("done_tag expected %0h actual %0h", e.done_tag, got.done_tag);
      errors++;
    end
    if (got.done_len !== e.done_len) begin
      $error("done_len expected %0h actual %0h", e.done_len, got.done_len);
      errors++;
    end
    if (got.freed_count !== e.freed_count) begin
      $error("freed_count expected %0d actual %0d", e.freed_count, got.freed_count);
      errors++;
    end
  endfunction
endclass

module tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = vqdm_pkg::OP_SUBMIT;
  logic [63:0] buf_addr = '0;
  logic [31:0] buf_len = '0;
  logic        device_writes = 1'b0;
  logic        chain_end = 1'b0;
  logic [15:0] request_tag = '0;
  logic [15:0] used_idx = '0;
  logic [7:0]  used_head = '0;
  logic [31:0] used_len = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  desc_index;
  logic        no_free;
  logic        notify;
  logic [15:0] avail_count;
  logic        nothing_ready;
  logic [15:0] done_tag;
  logic [31:0] done_len;
  logic [8:0]  freed_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = '0;

  vq_scoreboard sb = new();
  bit           quiet = 1'b0;
  int           stall_left = 0;
  longint       cycles = 0;
  logic [7:0]   pub_heads[$];

  virtqueue_descriptor_manager_unit #(.QUEUE_LEN(256)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .buf_addr(buf_addr), .buf_len(buf_len), .device_writes(device_writes),
    .chain_end(chain_end), .request_tag(request_tag), .used_idx(used_idx),
    .used_head(used_head), .used_len(used_len),
    .out_valid(out_valid), .out_stall(out_stall),
    .desc_index(desc_index), .no_free(no_free), .notify(notify),
    .avail_count(avail_count), .nothing_ready(nothing_ready), .done_tag(done_tag),
    .done_len(done_len), .freed_count(freed_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check('{desc_index: desc_index, no_free: no_free, notify: notify,
                 avail_count: avail_count, nothing_ready: nothing_ready,
                 done_tag: done_tag, done_len: done_len, freed_count: freed_count});
  end

  // Receiver stalls come in bursts.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send(bit o, bit [63:0] a, bit [31:0] l, bit dw, bit ce, bit [15:0] rt,
                      bit [15:0] ui, bit [7:0] uh, bit [31:0] ul);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    op <= o;
    buf_addr <= a;
    buf_len <= l;
    device_writes <= dw;
    chain_end <= ce;
    request_tag <= rt;
    used_idx <= ui;
    used_head <= uh;
    used_len <= ul;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(o, dw, ce, rt, ui, uh, ul);
    if (o == vqdm_pkg::OP_SUBMIT && sb.last_pub) pub_heads.push_back(sb.chead);
  endtask

  task automatic submit(bit ce);
    bit [63:0] a;
    a = {$urandom, $urandom};
    if ($urandom_range(0, 15) == 0) a = $urandom_range(0, 1) ? '1 : '0;
    send(vqdm_pkg::OP_SUBMIT, a, $urandom, 1'($urandom_range(0, 1)), ce, 16'($urandom),
         16'($urandom), 8'($urandom), $urandom);
  endtask

  task automatic poll_empty();
    send(vqdm_pkg::OP_CONSUME, {$urandom, $urandom}, $urandom, 1'($urandom_range(0, 1)),
         1'($urandom_range(0, 1)), 16'($urandom), sb.lused, 8'($urandom), $urandom);
  endtask

  // Completes the oldest published request or, if asked or unsafe, a random head; else polls.
  task automatic complete(bit any_head);
    bit [7:0]  h;
    bit [15:0] ui;
    bit        ok;
    int        tries;
    ok = 1'b0;
    if (!any_head && pub_heads.size() != 0) begin
      h = pub_heads.pop_front();
      ok = sb.safe(h);
    end
    for (tries = 0; tries < 8 && !ok; tries++) begin
      h = 8'($urandom);
      ok = sb.safe(h);
    end
    ui = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'(sb.lused + $urandom_range(1, 3));
    if (ui == sb.lused) ui++;
    if (!ok) begin
      poll_empty();
    end else begin
      send(vqdm_pkg::OP_CONSUME, {$urandom, $urandom}, $urandom, 1'($urandom_range(0, 1)),
           1'($urandom_range(0, 1)), 16'($urandom), ui, h,
           $urandom_range(0, 7) == 0 ? 32'hffff_ffff : $urandom);
    end
  endtask

  // The register is written only once the block has drained.
  task automatic write_qlog(bit [3:0] v);
    in_valid <= 1'b0;
    while (sb.want.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.qlog = v;
  endtask

  initial begin
    int i, k, phase;
    bit [3:0] plan[8];
    plan = '{4'd8, 4'd3, 4'd15, 4'd0, 4'd5, 4'd2, 4'd8, 4'd4};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, a three-buffer chain, polling, completion.
    send(vqdm_pkg::OP_SUBMIT, '1, '1, 1'b1, 1'b1, 16'hffff, '0, '0, '0);
    send(vqdm_pkg::OP_SUBMIT, '0, '0, 1'b0, 1'b0, 16'h0000, '1, '1, '1);
    send(vqdm_pkg::OP_SUBMIT, 64'h8000_0000_0000_0001, 32'h8000_0001, 1'b1, 1'b0, 16'h1234,
         '0, '0, '0);
    send(vqdm_pkg::OP_SUBMIT, 64'h5555_aaaa_5555_aaaa, 32'haaaa_5555, 1'b0, 1'b1, 16'h0000,
         '0, '0, '0);
    pub_heads.delete();
    poll_empty();
    send(vqdm_pkg::OP_CONSUME, '0, '0, 1'b0, 1'b0, '0, 16'hffff, 8'd0, 32'hffff_ffff);
    send(vqdm_pkg::OP_CONSUME, '0, '0, 1'b0, 1'b0, '0, 16'd2, 8'd1, 32'd0);
    poll_empty();

    // Tiny queue: run out of descriptors, including a chain end on a dropped buffer.
    write_qlog(4'd1);
    submit(1'b0);
    submit(1'b0);
    submit(1'b1);
    submit(1'b1);
    // Head far beyond the queue size folds back into it.
    send(vqdm_pkg::OP_CONSUME, '0, '0, 1'b0, 1'b0, '0, sb.lused + 16'd1, 8'hff, 32'd7);
    submit(1'b1);
    send(vqdm_pkg::OP_CONSUME, '0, '0, 1'b0, 1'b0, '0, sb.lused + 16'd1, 8'h00, 32'd9);
    write_qlog(4'd0);
    submit(1'b1);
    submit(1'b1);
    send(vqdm_pkg::OP_CONSUME, '0, '0, 1'b0, 1'b0, '0, sb.lused + 16'd1, 8'hfe, 32'd1);
    write_qlog(4'd15);
    submit(1'b1);
    pub_heads.delete();

    for (phase = 0; phase < 8; phase++) begin
      write_qlog(plan[phase]);
      pub_heads.delete();
      for (i = 0; i < 175; i++) begin
        if (phase == 7 && i >= 100) quiet = 1'b1;
        k = $urandom_range(0, 99);
        if (k < 48) submit($urandom_range(0, 9) < 4);
        else if (k < 84) complete(1'b0);
        else if (k < 93) complete(1'b1);
        else poll_empty();
      end
    end
    in_valid <= 1'b0;

    while (sb.want.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

`default_nettype wire
